[rtl/ipmac_pkg.sv]
// ----------------------------------------------------------------------------
// ipmac_pkg
// Shared types, codes and the control store of the IPv4-to-MAC table.
// ----------------------------------------------------------------------------
package ipmac_pkg;

    localparam int ENTRIES_DEF = 16;

    localparam int ACT_W  = 2;
    localparam int IP_W   = 32;
    localparam int MAC_W  = 48;
    localparam int STAT_W = 2;

    // action codes
    localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;

    typedef enum logic [1:0] {
        STEP_IDLE,
        STEP_SCAN,
        STEP_DRAIN,
        STEP_EXEC
    } step_t;

    // jump condition: jump to target when true, else hold the step
    typedef enum logic [1:0] {
        COND_ACCEPT,
        COND_SCAN_DONE,
        COND_ALWAYS,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        logic  in_rdy;   // take an input beat
        logic  scan_rd;  // read the slot memory at the scan index
        logic  exec;     // apply the action and load the result register
        cond_t cond;
        step_t target;
    } uword_t;

    function automatic uword_t ucode_rom(input step_t s);
        uword_t w;
        w = '{in_rdy: 1'b0, scan_rd: 1'b0, exec: 1'b0,
              cond: COND_ALWAYS, target: STEP_IDLE};
        case (s)
            STEP_IDLE:
            begin
                w.in_rdy = 1'b1;
                w.cond   = COND_ACCEPT;
                w.target = STEP_SCAN;
            end
            STEP_SCAN:
            begin
                w.scan_rd = 1'b1;
                w.cond    = COND_SCAN_DONE;
                w.target  = STEP_DRAIN;
            end
            STEP_DRAIN:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_EXEC;
            end
            STEP_EXEC:
            begin
                w.exec   = 1'b1;
                w.cond   = COND_OUT_FREE;
                w.target = STEP_IDLE;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

[rtl/ip_to_mac_translation_table_top.sv]
// ----------------------------------------------------------------------------
// ip_to_mac_translation_table_top
// ENTRIES-slot table mapping IPv4 addresses to MAC addresses (add, remove,
// lookup), run by a small microcoded sequencer over a slot memory.
// ----------------------------------------------------------------------------
// Each input beat is one action and yields exactly one result beat. An item
// is accepted in the idle step, then each slot is scanned through the slot
// memory's single registered read port, the last compare is made in the drain
// step and the action is applied in the exec step, which waits while a stalled
// consumer holds the result register. A finished result waits in the output
// register while the next item is accepted and scanned. Slot valid bits are
// flip-flops cleared by reset, so the block is ready right after reset with no
// clearing pass.
module ip_to_mac_translation_table_top
    import ipmac_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [ACT_W-1:0]  action,
    input  logic [IP_W-1:0]   ip_key,
    input  logic [MAC_W-1:0]  new_mac,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [STAT_W-1:0] status,
    output logic [MAC_W-1:0]  found_mac
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

    // sequencer
    step_t             step_reg, step_next;
    uword_t            uw;
    logic              cond_true;

    // item registers
    logic [ACT_W-1:0]  act_reg;
    logic [IP_W-1:0]   key_reg;
    logic [MAC_W-1:0]  mac_reg;

    // scan datapath
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              cmp_pend_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic [IP_W-1:0]   rd_ip_reg;
    logic [MAC_W-1:0]  rd_mac_reg;
    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [MAC_W-1:0]  hit_mac_reg;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic              match;

    // slot store
    logic              valid_reg [ENTRIES];
    logic              valid_next [ENTRIES];
    logic [IP_W-1:0]   slot_ip  [ENTRIES];
    logic [MAC_W-1:0]  slot_mac [ENTRIES];

    // action decode
    logic              in_accept;
    logic              out_free;
    logic              scan_done;
    logic              exec_fire;
    logic              wr_en;
    logic              set_valid;
    logic              clr_valid;
    logic [IDX_W-1:0]  wr_idx;
    logic [STAT_W-1:0] status_next;
    logic [MAC_W-1:0]  found_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] status_reg;
    logic [MAC_W-1:0]  found_mac_reg;

    assign uw        = ucode_rom(step_reg);
    assign in_stall  = !uw.in_rdy;
    assign in_accept = in_valid && uw.in_rdy;
    assign out_free  = !out_valid_reg || !out_stall;
    assign scan_done = (idx_reg == IDX_LAST);
    assign exec_fire = uw.exec && out_free;

    always_comb
    begin
        case (uw.cond)
            COND_ACCEPT:    cond_true = in_accept;
            COND_SCAN_DONE: cond_true = scan_done;
            COND_OUT_FREE:  cond_true = out_free;
            default:        cond_true = 1'b1;
        endcase
        step_next = cond_true ? uw.target : step_reg;
    end

    assign match = cmp_pend_reg && valid_reg[cmp_idx_reg] && (rd_ip_reg == key_reg);

    always_comb
    begin
        idx_next        = idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        if (in_accept)
        begin
            idx_next        = '0;
            hit_next        = 1'b0;
            free_found_next = 1'b0;
        end
        else
        begin
            if (uw.scan_rd && !scan_done)
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
            // keep the lowest free slot seen so far
            if (uw.scan_rd && !free_found_reg && !valid_reg[idx_reg])
            begin
                free_found_next = 1'b1;
                free_idx_next   = idx_reg;
            end
            if (match)
            begin
                hit_next     = 1'b1;
                hit_idx_next = cmp_idx_reg;
            end
        end
    end

    always_comb
    begin
        set_valid   = 1'b0;
        clr_valid   = 1'b0;
        wr_idx      = hit_idx_reg;
        status_next = ST_NOTFOUND;
        found_next  = '0;
        case (act_reg)
            ACT_ADD:
            begin
                if (hit_reg)
                begin
                    set_valid   = 1'b1;
                    status_next = ST_OK;
                end
                else if (free_found_reg)
                begin
                    set_valid   = 1'b1;
                    wr_idx      = free_idx_reg;
                    status_next = ST_OK;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            ACT_REMOVE:
            begin
                if (hit_reg)
                begin
                    clr_valid   = 1'b1;
                    status_next = ST_OK;
                end
            end
            ACT_LOOKUP:
            begin
                if (hit_reg)
                begin
                    status_next = ST_OK;
                    found_next  = hit_mac_reg;
                end
            end
            default:
            begin
                status_next = ST_NOTFOUND;
            end
        endcase
    end

    assign wr_en = exec_fire && set_valid;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            valid_next[i] = valid_reg[i];
        end
        if (exec_fire && set_valid)
        begin
            valid_next[wr_idx] = 1'b1;
        end
        if (exec_fire && clr_valid)
        begin
            valid_next[wr_idx] = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= STEP_IDLE;
            idx_reg        <= '0;
            cmp_pend_reg   <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            step_reg       <= step_next;
            idx_reg        <= idx_next;
            cmp_pend_reg   <= uw.scan_rd;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            out_valid_reg  <= out_valid_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid_reg[i] <= valid_next[i];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            act_reg <= action;
            key_reg <= ip_key;
            mac_reg <= new_mac;
        end
        cmp_idx_reg  <= idx_reg;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        if (match)
        begin
            hit_mac_reg <= rd_mac_reg;
        end
        if (exec_fire)
        begin
            status_reg    <= status_next;
            found_mac_reg <= found_next;
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_ip[wr_idx]  <= key_reg;
            slot_mac[wr_idx] <= mac_reg;
        end
        if (uw.scan_rd)
        begin
            rd_ip_reg  <= slot_ip[idx_reg];
            rd_mac_reg <= slot_mac[idx_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign found_mac = found_mac_reg;

endmodule

[rtl/ipmac_chk.sv]
// ----------------------------------------------------------------------------
// ipmac_chk
// Port-level checks for the IPv4-to-MAC table, bound to the top level.
// ----------------------------------------------------------------------------
module ipmac_chk
    import ipmac_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [STAT_W-1:0] status,
    input logic [MAC_W-1:0]  found_mac
);

    // one item at a time: busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an item is in progress");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_NOTFOUND || status == ST_FULL))
        else $error("result carries an unknown status code");

    a_mac_zero_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> found_mac == '0)
        else $error("nonzero MAC on a failed action");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(found_mac))
        else $error("stalled result beat changed");

endmodule

bind ip_to_mac_translation_table_top ipmac_chk u_ipmac_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .found_mac (found_mac)
);

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: IPv4-to-MAC translation table testbench
// Drives add, remove and lookup beats into the table and keeps a shadow copy
// of the slots to predict each result beat. Directed tests cover the address
// and MAC extremes, replacement, misses, the unused action code and a full
// table. Random traffic over a small key pool then fills, hits and drains the
// table under random sender bursts and receiver stalls, including one long
// receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_top
    import ipmac_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                ENTRIES    = ENTRIES_DEF;
    localparam logic [ACT_W-1:0]  ACT_UNUSED = 2'd3;
    localparam int                POOL_MAX   = 40;
    localparam int                HOLD_LEN   = 200;
    localparam int                DRAIN_MAX  = 20000;
    localparam int                TAIL_WAIT  = 40;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_t;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [MAC_W-1:0]  mac;
    } arp_reply_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [ACT_W-1:0]  action    = ACT_LOOKUP;
    logic [IP_W-1:0]   ip_key    = '0;
    logic [MAC_W-1:0]  new_mac   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [STAT_W-1:0] status;
    logic [MAC_W-1:0]  found_mac;

    // shadow of the slot table
    logic              shadow_valid [ENTRIES];
    logic [IP_W-1:0]   shadow_ip    [ENTRIES];
    logic [MAC_W-1:0]  shadow_mac   [ENTRIES];

    arp_reply_t        expected_replies [$];
    logic [IP_W-1:0]   key_pool [POOL_MAX];
    int                error_count = 0;
    bit                pacing      = 1'b0;
    int                burst_left  = 0;

    // receiver hold-off request: toggle to start one long stall
    logic              hold_token  = 1'b0;
    logic              hold_seen   = 1'b0;
    int                hold_left   = 0;
    logic [5:0]        rx_phase    = '0;
    rx_mode_t          rx_mode     = RX_FREE;

    ip_to_mac_translation_table_top #(
        .ENTRIES   (ENTRIES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .ip_key    (ip_key),
        .new_mac   (new_mac),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .found_mac (found_mac)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow table update and result prediction for one accepted beat
    // ------------------------------------------------------------------
    function automatic arp_reply_t arp_predict(input logic [ACT_W-1:0] act,
                                               input logic [IP_W-1:0]  ip,
                                               input logic [MAC_W-1:0] mac);
        arp_reply_t r;
        int         hit;
        int         spare;
        r.status = ST_NOTFOUND;
        r.mac    = '0;
        hit      = -1;
        spare    = -1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (shadow_valid[i] && shadow_ip[i] == ip && hit < 0)
                hit = i;
            if (!shadow_valid[i] && spare < 0)
                spare = i;
        end
        case (act)
            ACT_ADD:
            begin
                if (hit < 0)
                    hit = spare;
                if (hit < 0)
                    r.status = ST_FULL;
                else
                begin
                    shadow_valid[hit] = 1'b1;
                    shadow_ip[hit]    = ip;
                    shadow_mac[hit]   = mac;
                    r.status          = ST_OK;
                end
            end
            ACT_REMOVE:
            begin
                if (hit >= 0)
                begin
                    shadow_valid[hit] = 1'b0;
                    r.status          = ST_OK;
                end
            end
            ACT_LOOKUP:
            begin
                if (hit >= 0)
                begin
                    r.status = ST_OK;
                    r.mac    = shadow_mac[hit];
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[MAC_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Sender: one beat, with bursts and random gaps while pacing is on
    // ------------------------------------------------------------------
    task automatic send_item(input logic [ACT_W-1:0] act,
                             input logic [IP_W-1:0]  ip,
                             input logic [MAC_W-1:0] mac);
        int gap;
        gap = 0;
        if (pacing)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 9);
                burst_left = $urandom_range(1, 12);
            end
            else
                burst_left--;
        end
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        ip_key   <= ip;
        new_mac  <= mac;
        do
            @(posedge clk);
        while (in_stall);
        expected_replies.push_back(arp_predict(act, ip, mac));
    endtask

    task automatic send_random(input int pool_n);
        int              pick;
        logic [ACT_W-1:0] act;
        logic [IP_W-1:0]  ip;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            act = ACT_ADD;
        else if (pick < 65)
            act = ACT_REMOVE;
        else if (pick < 96)
            act = ACT_LOOKUP;
        else
            act = ACT_UNUSED;
        // mostly pool keys so hits and a full table happen; a few fresh misses
        if ($urandom_range(0, 9) == 0)
            ip = $urandom;
        else
            ip = key_pool[$urandom_range(0, pool_n - 1)];
        send_item(act, ip, rand_mac());
    endtask

    // Drop valid and hold off until every expected beat has come back or the drain limit runs out
    task automatic wait_drained();
        int waited;
        waited   = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_replies.size() != 0 && waited < DRAIN_MAX)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_basic_actions();
        send_item(ACT_LOOKUP, '0, '0);                  // empty table miss
        send_item(ACT_REMOVE, '1, '1);                  // remove absent
        send_item(ACT_ADD,    '0, '0);
        send_item(ACT_ADD,    '1, '1);
        send_item(ACT_LOOKUP, '1, '0);
        send_item(ACT_ADD,    '1, 48'h5555_AAAA_5555);  // replace in place
        send_item(ACT_LOOKUP, '1, '1);
        send_item(ACT_UNUSED, '1, '1);                  // no-op, reports miss
        send_item(ACT_REMOVE, '0, '1);
        send_item(ACT_LOOKUP, '0, '1);
    endtask

    task automatic test_table_full();
        // fill every free slot, then one more new address reports full
        for (int i = 1; i <= ENTRIES; i++)
            send_item(ACT_ADD, 32'h0A00_0000 + i, rand_mac());
        send_item(ACT_ADD,    32'h0A00_0002, 48'hA0A0_0000_0002);
        send_item(ACT_REMOVE, 32'h0A00_0003, '0);
        send_item(ACT_ADD,    32'hC0A8_0001, 48'h8000_0000_0001);
        send_item(ACT_LOOKUP, 32'hC0A8_0001, '0);
    endtask

    task automatic test_backpressure();
        pacing     = 1'b0;
        hold_token <= ~hold_token;
        for (int i = 0; i < 24; i++)
            send_random(16);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        pacing = 1'b1;
        for (int i = 0; i < 140; i++)
            send_random(24);
        pacing = 1'b0;
        for (int i = 0; i < 120; i++)
            send_random(8);
        pacing = 1'b1;
        for (int i = 0; i < 140; i++)
            send_random(POOL_MAX);
    endtask

    // ------------------------------------------------------------------
    // Receiver stall pattern and the long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= HOLD_LEN;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            rx_phase <= rx_phase + 1'b1;
            if (rx_phase == '0)
                rx_mode <= rx_mode_t'($urandom_range(0, 2));
            case (rx_mode)
                RX_FREE:    out_stall <= 1'b0;
                RX_RANDOM:  out_stall <= ($urandom_range(0, 99) < 40);
                RX_PATTERN: out_stall <= (rx_phase[2:0] < 3'd3);
                default:    out_stall <= 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        arp_reply_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_replies.size() == 0)
            begin
                $error("unexpected result beat: status=%0d found_mac=%h",
                       status, found_mac);
                error_count++;
            end
            else
            begin
                exp_r = expected_replies.pop_front();
                if (status !== exp_r.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_r.status, status);
                    error_count++;
                end
                if (found_mac !== exp_r.mac)
                begin
                    $error("found_mac: expected %h, actual %h", exp_r.mac, found_mac);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_ip[i]    = '0;
            shadow_mac[i]   = '0;
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_MAX; i++)
            key_pool[i] = $urandom;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_actions();
        test_table_full();
        wait_drained();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        if (expected_replies.size() != 0)
        begin
            $error("%0d result beats never arrived", expected_replies.size());
            error_count++;
        end
        repeat (TAIL_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
